// ----- hdl/sled_pkg.sv -----
package sled_pkg;

  localparam logic [1:0] FUNC_INIT     = 2'd0;
  localparam logic [1:0] FUNC_SET_MODE = 2'd1;
  localparam logic [1:0] FUNC_REFRESH  = 2'd2;

  localparam logic [2:0] MODE_IDLE         = 3'd0;
  localparam logic [2:0] MODE_LISTENING    = 3'd1;
  localparam logic [2:0] MODE_PROCESSING   = 3'd2;
  localparam logic [2:0] MODE_PLAYING      = 3'd3;
  localparam logic [2:0] MODE_ERROR        = 3'd4;
  localparam logic [2:0] MODE_PROVISIONING = 3'd5;

  localparam logic [9:0] INTERVAL_RESET = 10'd30;

  // Remainder width; the longest period is 3000 ms.
  localparam int DivW = 13;

  localparam logic [DivW-1:0] BLINK_PERIOD  = 13'd500;   // two 250 ms halves
  localparam logic [DivW-1:0] SLOW_PERIOD   = 13'd3000;
  localparam logic [DivW-1:0] FAST_PERIOD   = 13'd1200;
  localparam logic [DivW-1:0] BLINK_HALF    = 13'd250;
  localparam logic [DivW-1:0] SLOW_HALF     = 13'd1500;
  localparam logic [DivW-1:0] FAST_HALF     = 13'd600;

  // Division by a constant multiplies by a rounded-up reciprocal: floor(n * m / 2^s)
  // equals floor(n / d) over the whole range of n. The time is shifted down first,
  // as 500 = 4 * 125, 3000 = 8 * 375 and 1200 = 16 * 75.
  localparam logic [31:0] BLINK_MAGIC = 32'd1099511628;  // 2^37 / 125
  localparam logic [31:0] SLOW_MAGIC  = 32'd733007752;   // 2^38 / 375
  localparam logic [31:0] FAST_MAGIC  = 32'd458129845;   // 2^35 / 75
  // Breath scaling folds the trailing /4 or /6 into the divisor: floor(floor(x/h)/k) =
  // floor(x/(h*k)).
  localparam logic [31:0] SLOW_QUARTER_MAGIC = 32'd715828;     // 2^32 / 6000
  localparam logic [31:0] FAST_QUARTER_MAGIC = 32'd1789570;    // 2^32 / 2400
  localparam logic [31:0] FAST_SIXTH_MAGIC   = 32'd1193047;    // 2^32 / 3600
  localparam logic [31:0] FIFTH_MAGIC        = 32'd858993460;  // 2^32 / 5

  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_DIM   = 8'd64;
  localparam logic [7:0] LEVEL_PLAY  = 8'd48;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  mode;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

endpackage

// ----- hdl/status_led_pattern_generator.sv -----
// Channel  Direction  Handshake                 Payload
// item     in         item_valid / item_stall   item_t  (func, mode, now_ms)
// color    out        color_valid / color_stall color_t (red, green, blue)
// cfg      in         cfg_we                    cfg_wdata (refresh interval, ms)
//
// Init, set mode, constant colors and skipped refreshes skip the multiplier states.
// Blink and breath refreshes share one 32 x 32 multiplier for constant division:
// blink runs quotient, remainder, prep; breath adds scale, processing green too.
// item_stall is high until the color is handed to the output register.
// Synchronous reset restores idle mode, time zero and a 30 ms interval.
// A finished color waits while the output register holds a stalled transfer.
module status_led_pattern_generator
  import sled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        color_valid,
  input  logic        color_stall,
  output color_t      color,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_QUOT  = 7'b0000010,
    S_REM   = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_GREEN = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t          state;
  logic [2:0]      current_mode;
  logic [31:0]     last_refresh_time;
  logic [9:0]      interval;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [DivW-1:0] rem;
  color_t          res;

  logic            accept;
  logic            emit_go;
  logic [31:0]     elapsed;
  logic            too_soon;
  logic [63:0]     prod;
  logic [31:0]     quot;
  logic [31:0]     rem_full;
  logic [31:0]     mod_operand;
  logic [31:0]     mod_magic;
  logic [31:0]     scale_magic;
  logic [DivW-1:0] period;
  logic [DivW-1:0] half;
  logic [DivW-1:0] trough_dist;
  logic [19:0]     scaled;
  logic [7:0]      level;
  logic [9:0]      level_x3;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign emit_go    = (state == S_EMIT) && (!color_valid || !color_stall);
  assign elapsed    = item.now_ms - last_refresh_time;
  assign too_soon   = elapsed < {22'd0, interval};

  assign prod     = 64'(mul_a) * 64'(mul_b);
  // The refresh time was already stored, so the remainder comes from it.
  assign rem_full = last_refresh_time - prod[31:0];

  always_comb begin
    mod_operand = {4'd0, item.now_ms[31:4]};
    mod_magic   = FAST_MAGIC;
    quot        = {3'd0, prod[63:35]};
    period      = FAST_PERIOD;
    half        = FAST_HALF;
    scale_magic = FAST_QUARTER_MAGIC;
    unique case (current_mode)
      MODE_ERROR: begin
        mod_operand = {2'd0, item.now_ms[31:2]};
        mod_magic   = BLINK_MAGIC;
        quot        = {5'd0, prod[63:37]};
        period      = BLINK_PERIOD;
      end
      MODE_IDLE: begin
        mod_operand = {3'd0, item.now_ms[31:3]};
        mod_magic   = SLOW_MAGIC;
        quot        = {6'd0, prod[63:38]};
        period      = SLOW_PERIOD;
        half        = SLOW_HALF;
        scale_magic = SLOW_QUARTER_MAGIC;
      end
      MODE_PROVISIONING: begin
        scale_magic = FAST_SIXTH_MAGIC;
      end
      default: begin
      end
    endcase
  end

  // Distance from the nearest trough of the triangle wave.
  assign trough_dist = (rem < half) ? rem : DivW'(period - rem);
  assign scaled      = 20'(trough_dist) * 20'(LEVEL_FULL);
  assign level       = prod[39:32];
  assign level_x3    = 10'(level) * 10'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      current_mode      <= MODE_IDLE;
      last_refresh_time <= '0;
      interval          <= INTERVAL_RESET;
      color_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        interval <= cfg_wdata;
      end
      if (emit_go) begin
        color       <= res;
        color_valid <= 1'b1;
      end else if (color_valid && !color_stall) begin
        color_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (item.func)
              FUNC_INIT: begin
                res   <= '0;
                state <= S_EMIT;
              end
              FUNC_SET_MODE: begin
                if (item.mode != current_mode) begin
                  current_mode <= item.mode;
                  res          <= '0;
                  state        <= S_EMIT;
                end
              end
              FUNC_REFRESH: begin
                if (!too_soon) begin
                  last_refresh_time <= item.now_ms;
                  priority case (current_mode)
                    MODE_LISTENING: begin
                      res   <= {8'd0, LEVEL_DIM, 8'd0};
                      state <= S_EMIT;
                    end
                    MODE_PLAYING: begin
                      res   <= {8'd0, LEVEL_PLAY, LEVEL_PLAY};
                      state <= S_EMIT;
                    end
                    MODE_IDLE, MODE_PROCESSING, MODE_ERROR, MODE_PROVISIONING: begin
                      res   <= '0;
                      mul_a <= mod_operand;
                      mul_b <= mod_magic;
                      state <= S_QUOT;
                    end
                    default: begin
                      res   <= '0;
                      state <= S_EMIT;
                    end
                  endcase
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_QUOT: begin
          mul_a <= quot;
          mul_b <= {19'd0, period};
          state <= S_REM;
        end

        S_REM: begin
          rem   <= rem_full[DivW-1:0];
          state <= S_PREP;
        end

        S_PREP: begin
          if (current_mode == MODE_ERROR) begin
            // The blink is on during the odd 250 ms slots.
            res.red <= (rem >= BLINK_HALF) ? LEVEL_DIM : 8'd0;
            state   <= S_EMIT;
          end else begin
            mul_a <= {12'd0, scaled};
            mul_b <= scale_magic;
            state <= S_SCALE;
          end
        end

        S_SCALE: begin
          priority case (current_mode)
            MODE_IDLE: begin
              res.blue <= level;
              state    <= S_EMIT;
            end
            MODE_PROCESSING: begin
              res.red <= level;
              mul_a   <= {22'd0, level_x3};
              mul_b   <= FIFTH_MAGIC;
              state   <= S_GREEN;
            end
            default: begin
              res.red   <= level;
              res.green <= level;
              res.blue  <= level;
              state     <= S_EMIT;
            end
          endcase
        end

        S_GREEN: begin
          res.green <= level;
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> (rem < period))
    else $error("time remainder reached the period");

  a_early_refresh_keeps_time: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_REFRESH && too_soon) |=>
      ($stable(last_refresh_time) && state == S_IDLE))
    else $error("refresh inside the interval was not skipped");

  a_same_mode_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_SET_MODE && item.mode == current_mode) |=>
      (state == S_IDLE && $stable(current_mode)))
    else $error("set mode with the held mode produced a transfer");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && color_valid && color_stall) |=> (state == S_EMIT && $stable(res)))
    else $error("pending color lost while output was stalled");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sled_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       color_valid;
  logic       color_stall;
  color_t     color;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  status_led_pattern_generator dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .color_valid(color_valid),
    .color_stall(color_stall),
    .color(color),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  item_t       pending_items[$];
  color_t      expected_colors[$];
  logic        item_taken;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  // Shadow copy of the block's state and register.
  logic [2:0]  mode_model;
  logic [31:0] last_refresh_model;
  logic [9:0]  interval_model;

  int unsigned items_accepted = 0;
  int unsigned colors_checked = 0;
  int unsigned refreshes_skipped = 0;
  int unsigned intervals_written;
  int unsigned error_count = 0;
  int unsigned cycle_count;

  logic [31:0] stim_time;
  logic [9:0]  stim_interval;

  always #5 clk = ~clk;

  function automatic logic [7:0] breath_level(input logic [31:0] t, input int unsigned period);
    int unsigned u;
    int unsigned h;
    int unsigned d;
    u = t % period;
    h = period / 2;
    d = (u < h) ? u : (period - u);
    return 8'((d * 255) / h);
  endfunction

  function automatic color_t pattern_color(input logic [2:0] m, input logic [31:0] t);
    color_t     c;
    logic [7:0] v;
    c = '0;
    case (m)
      MODE_IDLE: begin
        c.blue = 8'(breath_level(t, 3000) / 4);
      end
      MODE_LISTENING: begin
        c.green = 8'd64;
      end
      MODE_PROCESSING: begin
        v = 8'(breath_level(t, 1200) / 4);
        c.red = v;
        c.green = 8'((v * 3) / 5);
      end
      MODE_PLAYING: begin
        c.green = 8'd48;
        c.blue = 8'd48;
      end
      MODE_ERROR: begin
        if (((t / 250) & 1) != 0) c.red = 8'd64;
      end
      MODE_PROVISIONING: begin
        v = 8'(breath_level(t, 1200) / 6);
        c.red = v;
        c.green = v;
        c.blue = v;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  task automatic predict_item(input item_t it);
    case (it.func)
      FUNC_INIT: begin
        expected_colors.push_back('0);
      end
      FUNC_SET_MODE: begin
        if (it.mode != mode_model) begin
          mode_model = it.mode;
          expected_colors.push_back('0);
        end
      end
      FUNC_REFRESH: begin
        if ((it.now_ms - last_refresh_model) < {22'd0, interval_model}) begin
          refreshes_skipped++;
        end else begin
          last_refresh_model = it.now_ms;
          expected_colors.push_back(pattern_color(mode_model, it.now_ms));
        end
      end
      default: ;
    endcase
  endtask

  // Prediction on accepted items and checking of accepted colors.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
      mode_model = MODE_IDLE;
      last_refresh_model = '0;
      interval_model = INTERVAL_RESET;
    end else begin
      if (color_valid && !color_stall) begin
        if (expected_colors.size() == 0) begin
          if (error_count < 10)
            $display("ERROR: color %0d/%0d/%0d arrived with none expected",
                     color.red, color.green, color.blue);
          error_count++;
        end else begin
          if (color.red !== expected_colors[0].red ||
              color.green !== expected_colors[0].green ||
              color.blue !== expected_colors[0].blue) begin
            if (error_count < 10)
              $display("ERROR: color r/g/b expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       expected_colors[0].red, expected_colors[0].green,
                       expected_colors[0].blue, color.red, color.green, color.blue);
            error_count++;
          end
          void'(expected_colors.pop_front());
          colors_checked++;
        end
      end
      if (cfg_we) interval_model = cfg_wdata;
      item_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        items_accepted++;
        predict_item(item);
      end
    end
  end

  // Driver and receiver stalls change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      color_stall <= 1'b0;
    end else begin
      color_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
      if (!item_valid || item_taken) begin
        if (pending_items.size() != 0 &&
            !((sender_idle_pct != 0) && ($urandom_range(99) < sender_idle_pct))) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic queue_item(input logic [1:0] f, input logic [2:0] m, input logic [31:0] t);
    pending_items.push_back(item_t'{f, m, t});
  endtask

  // Sender holds off until the block has gone quiet.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [9:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    stim_interval = value;
    intervals_written++;
  endtask

  // Mostly forward-moving refresh times around the interval, with set-mode and
  // init transfers mixed in, plus occasional jumps and unused function codes.
  task automatic queue_random_items(input int count);
    int unsigned pick;
    int          n;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        if ($urandom_range(29) == 0) stim_time = $urandom;
        else stim_time = stim_time + $urandom_range(0, 2 * stim_interval + 2);
        queue_item(FUNC_REFRESH, 3'($urandom_range(7)), stim_time);
        n++;
      end else if (pick < 86) begin
        queue_item(FUNC_SET_MODE, 3'($urandom_range(7)), $urandom);
        n++;
      end else if (pick < 96) begin
        queue_item(FUNC_INIT, 3'($urandom_range(7)), $urandom);
        n++;
      end else begin
        queue_item(FUNC_UNUSED, 3'($urandom_range(7)), $urandom);
      end
    end
  endtask

  initial begin
    logic [9:0] phase_interval[RANDOM_PHASES];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    intervals_written = 0;
    stim_interval = INTERVAL_RESET;
    phase_interval = '{10'd0, 10'd1000, 10'd30, 10'd5, 10'($urandom_range(1000)),
                       10'd1, 10'd250, 10'($urandom_range(1000))};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset interval.
    queue_item(FUNC_INIT, 3'd7, 32'hFFFF_FFFF);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd29);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd30);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd1500);
    queue_item(FUNC_SET_MODE, MODE_IDLE, 32'd0);
    queue_item(FUNC_SET_MODE, MODE_ERROR, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd1750);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd2000);
    queue_item(FUNC_SET_MODE, MODE_LISTENING, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd2100);
    queue_item(FUNC_SET_MODE, MODE_PROCESSING, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd3000);
    queue_item(FUNC_SET_MODE, MODE_PLAYING, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd3100);
    queue_item(FUNC_SET_MODE, MODE_PROVISIONING, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd4200);
    queue_item(FUNC_SET_MODE, 3'd6, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd5000);
    queue_item(FUNC_SET_MODE, 3'd7, 32'd0);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'hFFFF_FFFF);
    queue_item(FUNC_SET_MODE, MODE_IDLE, 32'd0);
    // Across the wrap: 5 ms elapsed is too soon, 41 ms is enough.
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd4);
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd40);
    // A time going backward reads as a huge elapsed time.
    queue_item(FUNC_REFRESH, MODE_IDLE, 32'd10);
    queue_item(FUNC_UNUSED, 3'd7, 32'hFFFF_FFFF);
    wait_drained();
    stim_time = 32'd100;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_interval(phase_interval[p]);
      sender_idle_pct = (p % 4 == 1 || p % 4 == 3) ? 68 : 0;
      receiver_stall_pct = (p % 4 == 2) ? 68 : ((p % 4 == 3) ? 34 : 0);
      if (p % 4 == 3) sender_idle_pct = 34;
      queue_random_items(ITEMS_PER_PHASE / 2);
      wait_drained();
      queue_random_items(ITEMS_PER_PHASE / 2);
      wait_drained();
    end

    $display("Run covered %0d accepted items, %0d colors checked, %0d refreshes skipped,",
             items_accepted, colors_checked, refreshes_skipped);
    $display("over %0d interval settings from 0 to 1000 ms and four idling mixes.",
             intervals_written);
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d colors still expected", error_count,
               expected_colors.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

endmodule
